>>> hw/rtl/dhtt_pkg.sv
// Shared types and constants of the double-hash term table.
package dhtt_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_NEW_EMPTY = 3'd1,
      ST_NEW_DEL   = 3'd2,
      ST_ABSENT    = 3'd3,
      ST_FULL      = 3'd4,
      ST_DELETED   = 3'd5,
      ST_IGNORED   = 3'd6
   } result_type;

   typedef enum logic {
      CSR_BUCKET_COUNT   = 1'b0,
      CSR_GROW_THRESHOLD = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_DIVIDE,
      FSM_SEED,
      FSM_READ,
      FSM_EVAL,
      FSM_WRITE,
      FSM_DEL_READ,
      FSM_DEL_EVAL,
      FSM_RESPOND
   } fsm_type;

   // Slot flag encoding: bit 1 marks empty, bit 0 marks deleted.
   localparam logic [1:0] FLAG_EMPTY = 2'b10;
   localparam logic [1:0] FLAG_DEL   = 2'b01;
   localparam logic [1:0] FLAG_LIVE  = 2'b00;

   localparam int CFG_W      = 11;
   localparam int WORD_W     = 32;
   localparam int PORT_SLOT_W = 10;
   localparam int DIV_STEPS  = 32;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       seed;
      logic       advance;
      logic       mark_reuse;
      logic       latch_tgt;
      logic       tgt_reuse;
      logic       set_status;
      result_type status_code;
      logic       write_entry;
      logic       mark_deleted;
      logic       clear_step;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       div_last;
      logic       flag_empty;
      logic       flag_del;
      logic       key_match;
      logic       wrap;
      logic       reuse_valid;
      logic       reuse_any;
      logic       idx_ok;
      logic       clr_last;
      logic       rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/double_hash_term_table_unit.sv
// Lookup and insert pass through the accepting state, the 32 remainder steps, a seed state, a
// read and an evaluate state for each slot probed, a write state for an insert and a state that
// loads the response. A delete reads and evaluates the indexed slot, then loads the response.
// One word is in flight at a time; the probe walk makes one registered read per probe. Reset
// is synchronous; afterwards a clearing pass marks all MAX_BUCKETS slots empty, one a cycle,
// before the first word is taken.
module double_hash_term_table_unit #(
   parameter int MAX_BUCKETS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [dhtt_pkg::CFG_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [dhtt_pkg::WORD_W-1:0]       req_key_word,
   input  logic [dhtt_pkg::WORD_W-1:0]       req_key_field,
   input  logic [dhtt_pkg::WORD_W-1:0]       req_value,
   input  logic [dhtt_pkg::PORT_SLOT_W-1:0]  req_slot_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [dhtt_pkg::PORT_SLOT_W-1:0]  rsp_slot,
   output logic [dhtt_pkg::WORD_W-1:0]       rsp_read_value,
   output logic [dhtt_pkg::CFG_W-1:0]        rsp_entry_count,
   output logic                              rsp_needs_grow
);

   logic [dhtt_pkg::CFG_W-1:0] bucket_count_ff;
   logic [dhtt_pkg::CFG_W-1:0] grow_threshold_ff;
   dhtt_pkg::cmd_type          cmd;
   dhtt_pkg::sts_type          sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff   <= dhtt_pkg::CFG_W'(3);
         grow_threshold_ff <= dhtt_pkg::CFG_W'(2);
      end else if (csr_write) begin
         unique case (csr_index)
            dhtt_pkg::CSR_BUCKET_COUNT:   bucket_count_ff   <= csr_data;
            dhtt_pkg::CSR_GROW_THRESHOLD: grow_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dhtt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   dhtt_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_key_word    (req_key_word),
      .req_key_field   (req_key_field),
      .req_value       (req_value),
      .req_slot_index  (req_slot_index),
      .bucket_count    (bucket_count_ff),
      .grow_threshold  (grow_threshold_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_needs_grow  (rsp_needs_grow)
   );

endmodule

>>> hw/rtl/dhtt_ctrl.sv
// Sequencer of the double-hash term table: probe walk, writes and responses.
module dhtt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_operation,
   output logic               req_stall,
   output dhtt_pkg::cmd_type  cmd,
   input  dhtt_pkg::sts_type  sts
);

   dhtt_pkg::fsm_type state_ff;
   dhtt_pkg::fsm_type state_in;
   logic              lookup;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhtt_pkg::FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign lookup = (sts.op == dhtt_pkg::OP_LOOKUP);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != dhtt_pkg::FSM_IDLE);
      unique case (state_ff)
         dhtt_pkg::FSM_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clr_last) begin
               state_in = dhtt_pkg::FSM_IDLE;
            end
         end
         dhtt_pkg::FSM_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_operation)
                  dhtt_pkg::OP_LOOKUP, dhtt_pkg::OP_INSERT: begin
                     state_in = dhtt_pkg::FSM_DIVIDE;
                  end
                  dhtt_pkg::OP_DELETE: begin
                     state_in = dhtt_pkg::FSM_DEL_READ;
                  end
                  default: begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = dhtt_pkg::ST_IGNORED;
                     state_in        = dhtt_pkg::FSM_RESPOND;
                  end
               endcase
            end
         end
         dhtt_pkg::FSM_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = dhtt_pkg::FSM_SEED;
            end
         end
         dhtt_pkg::FSM_SEED: begin
            cmd.seed = 1'b1;
            state_in = dhtt_pkg::FSM_READ;
         end
         dhtt_pkg::FSM_READ: begin
            state_in = dhtt_pkg::FSM_EVAL;
         end
         dhtt_pkg::FSM_EVAL: begin
            cmd.set_status = 1'b1;
            if (sts.flag_empty) begin
               if (lookup) begin
                  cmd.status_code = dhtt_pkg::ST_ABSENT;
                  state_in        = dhtt_pkg::FSM_RESPOND;
               end else begin
                  cmd.latch_tgt   = 1'b1;
                  cmd.tgt_reuse   = sts.reuse_valid;
                  cmd.status_code = sts.reuse_valid ? dhtt_pkg::ST_NEW_DEL
                                                    : dhtt_pkg::ST_NEW_EMPTY;
                  state_in        = dhtt_pkg::FSM_WRITE;
               end
            end else if (!sts.flag_del && sts.key_match) begin
               cmd.latch_tgt   = 1'b1;
               cmd.status_code = dhtt_pkg::ST_FOUND;
               state_in        = lookup ? dhtt_pkg::FSM_RESPOND : dhtt_pkg::FSM_WRITE;
            end else begin
               cmd.mark_reuse = sts.flag_del;
               cmd.advance    = 1'b1;
               if (sts.wrap) begin
                  if (lookup) begin
                     cmd.status_code = dhtt_pkg::ST_ABSENT;
                     state_in        = dhtt_pkg::FSM_RESPOND;
                  end else if (sts.reuse_any) begin
                     cmd.latch_tgt   = 1'b1;
                     cmd.tgt_reuse   = 1'b1;
                     cmd.status_code = dhtt_pkg::ST_NEW_DEL;
                     state_in        = dhtt_pkg::FSM_WRITE;
                  end else begin
                     cmd.status_code = dhtt_pkg::ST_FULL;
                     state_in        = dhtt_pkg::FSM_RESPOND;
                  end
               end else begin
                  cmd.set_status = 1'b0;
                  state_in       = dhtt_pkg::FSM_READ;
               end
            end
         end
         dhtt_pkg::FSM_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = dhtt_pkg::FSM_RESPOND;
         end
         dhtt_pkg::FSM_DEL_READ: begin
            state_in = dhtt_pkg::FSM_DEL_EVAL;
         end
         dhtt_pkg::FSM_DEL_EVAL: begin
            cmd.set_status = 1'b1;
            if (sts.idx_ok && !sts.flag_empty && !sts.flag_del) begin
               cmd.mark_deleted = 1'b1;
               cmd.status_code  = dhtt_pkg::ST_DELETED;
            end else begin
               cmd.status_code  = dhtt_pkg::ST_IGNORED;
            end
            state_in = dhtt_pkg::FSM_RESPOND;
         end
         dhtt_pkg::FSM_RESPOND: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = dhtt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = dhtt_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/dhtt_datapath.sv
// Datapath of the double-hash term table: dividers, probe walk, slot memories, counters.
module dhtt_datapath #(
   parameter int MAX_BUCKETS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dhtt_pkg::cmd_type                   cmd,
   output dhtt_pkg::sts_type                   sts,
   input  logic [1:0]                          req_operation,
   input  logic [dhtt_pkg::WORD_W-1:0]         req_key_word,
   input  logic [dhtt_pkg::WORD_W-1:0]         req_key_field,
   input  logic [dhtt_pkg::WORD_W-1:0]         req_value,
   input  logic [dhtt_pkg::PORT_SLOT_W-1:0]    req_slot_index,
   input  logic [dhtt_pkg::CFG_W-1:0]          bucket_count,
   input  logic [dhtt_pkg::CFG_W-1:0]          grow_threshold,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [dhtt_pkg::PORT_SLOT_W-1:0]    rsp_slot,
   output logic [dhtt_pkg::WORD_W-1:0]         rsp_read_value,
   output logic [dhtt_pkg::CFG_W-1:0]          rsp_entry_count,
   output logic                                rsp_needs_grow
);

   localparam int SLOT_W = $clog2(MAX_BUCKETS);
   localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
   localparam int CNT_W  = (NB_W > dhtt_pkg::CFG_W) ? NB_W : dhtt_pkg::CFG_W;
   localparam int KV_W   = 3 * dhtt_pkg::WORD_W;
   localparam int STEP_W = $clog2(dhtt_pkg::DIV_STEPS);

   // Operation registers.
   logic [1:0]                        op_ff;
   logic [dhtt_pkg::WORD_W-1:0]       w_ff, f_ff, v_ff;
   logic [dhtt_pkg::PORT_SLOT_W-1:0]  idx_ff;
   logic [NB_W-1:0]                   nb_ff, nb_in;
   logic [31:0]                       bc_wide;

   // Remainder units.
   logic [dhtt_pkg::WORD_W-1:0]       kshift_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic [NB_W-1:0]                   rem_a_ff, rem_b_ff, rem_a_in, rem_b_in;
   logic [NB_W:0]                     ra_sh, rb_sh, nb_ext, nbm1_ext;

   // Probe walk.
   logic [SLOT_W-1:0]                 i_ff, start_ff, reuse_ff, target_ff, i_in;
   logic [NB_W-1:0]                   inc_ff;
   logic                              reuse_valid_ff;
   logic [NB_W:0]                     sum, next_wide;

   // Slot memories.
   logic [KV_W-1:0]                   kv_mem [MAX_BUCKETS];
   logic [1:0]                        flag_mem [MAX_BUCKETS];
   logic [KV_W-1:0]                   kv_rd_ff;
   logic [1:0]                        flag_rd_ff;
   logic                              flag_we;
   logic [SLOT_W-1:0]                 flag_addr;
   logic [1:0]                        flag_wdata;
   logic [SLOT_W-1:0]                 clr_cnt_ff;

   // Counters and result.
   logic [CNT_W-1:0]                  live_ff, used_ff;
   dhtt_pkg::result_type              status_ff;
   logic                              rsp_valid_ff;
   logic [2:0]                        rsp_status_ff;
   logic [dhtt_pkg::PORT_SLOT_W-1:0]  rsp_slot_ff, slot_res;
   logic [dhtt_pkg::WORD_W-1:0]       rsp_value_ff, value_res;
   logic [dhtt_pkg::CFG_W-1:0]        rsp_count_ff;
   logic                              rsp_grow_ff;
   logic                              placed;

   // Effective bucket count: clamped to at least three and at most the store depth.
   always_comb begin
      bc_wide = 32'(bucket_count);
      if (bc_wide < 32'd3) begin
         bc_wide = 32'd3;
      end else if (bc_wide > 32'(MAX_BUCKETS)) begin
         bc_wide = 32'(MAX_BUCKETS);
      end
      nb_in = NB_W'(bc_wide);
   end

   // One restoring step of each remainder per cycle, most significant bit first.
   assign nb_ext   = {1'b0, nb_ff};
   assign nbm1_ext = {1'b0, nb_ff} - (NB_W + 1)'(1);
   assign ra_sh    = {rem_a_ff, kshift_ff[dhtt_pkg::WORD_W-1]};
   assign rb_sh    = {rem_b_ff, kshift_ff[dhtt_pkg::WORD_W-1]};
   assign rem_a_in = (ra_sh >= nb_ext) ? NB_W'(ra_sh - nb_ext) : NB_W'(ra_sh);
   assign rem_b_in = (rb_sh >= nbm1_ext) ? NB_W'(rb_sh - nbm1_ext) : NB_W'(rb_sh);

   assign sum       = {1'b0, NB_W'(i_ff)} + {1'b0, inc_ff};
   assign next_wide = (sum >= nb_ext) ? (sum - nb_ext) : sum;
   assign i_in      = SLOT_W'(next_wide);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         w_ff      <= req_key_word;
         f_ff      <= req_key_field;
         v_ff      <= req_value;
         idx_ff    <= req_slot_index;
         nb_ff     <= nb_in;
         kshift_ff <= req_key_word ^ req_key_field;
         rem_a_ff  <= '0;
         rem_b_ff  <= '0;
         step_ff   <= '0;
         i_ff      <= SLOT_W'(req_slot_index);
      end
      if (cmd.div_step) begin
         rem_a_ff  <= rem_a_in;
         rem_b_ff  <= rem_b_in;
         kshift_ff <= {kshift_ff[dhtt_pkg::WORD_W-2:0], 1'b0};
         step_ff   <= step_ff + STEP_W'(1);
      end
      if (cmd.seed) begin
         i_ff           <= SLOT_W'(rem_a_ff);
         start_ff       <= SLOT_W'(rem_a_ff);
         inc_ff         <= rem_b_ff + NB_W'(1);
         reuse_valid_ff <= 1'b0;
      end
      if (cmd.latch_tgt) begin
         target_ff <= (cmd.tgt_reuse && !flag_rd_ff[0]) ? reuse_ff : i_ff;
      end
      if (cmd.mark_reuse) begin
         reuse_ff       <= i_ff;
         reuse_valid_ff <= 1'b1;
      end
      if (cmd.advance) begin
         i_ff <= i_in;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   // Key and value store: one write port, one registered read port at the probe slot.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         kv_mem[target_ff] <= {w_ff, f_ff, v_ff};
      end
      kv_rd_ff <= kv_mem[i_ff];
   end

   always_comb begin
      flag_we    = 1'b0;
      flag_addr  = i_ff;
      flag_wdata = dhtt_pkg::FLAG_DEL;
      if (cmd.clear_step) begin
         flag_we    = 1'b1;
         flag_addr  = clr_cnt_ff;
         flag_wdata = dhtt_pkg::FLAG_EMPTY;
      end else if (cmd.write_entry) begin
         flag_we    = 1'b1;
         flag_addr  = target_ff;
         flag_wdata = dhtt_pkg::FLAG_LIVE;
      end else if (cmd.mark_deleted) begin
         flag_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_addr] <= flag_wdata;
      end
      flag_rd_ff <= flag_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         used_ff <= '0;
      end else begin
         if (cmd.write_entry) begin
            if (status_ff == dhtt_pkg::ST_NEW_EMPTY) begin
               live_ff <= live_ff + CNT_W'(1);
               used_ff <= used_ff + CNT_W'(1);
            end else if (status_ff == dhtt_pkg::ST_NEW_DEL) begin
               live_ff <= live_ff + CNT_W'(1);
            end
         end
         if (cmd.mark_deleted && (live_ff != '0)) begin
            live_ff <= live_ff - CNT_W'(1);
         end
      end
   end

   // Result word.
   assign placed = (status_ff == dhtt_pkg::ST_FOUND) || (status_ff == dhtt_pkg::ST_NEW_EMPTY)
                   || (status_ff == dhtt_pkg::ST_NEW_DEL);

   always_comb begin
      slot_res  = '0;
      value_res = '0;
      if (op_ff == dhtt_pkg::OP_DELETE) begin
         slot_res = idx_ff;
      end else if (placed) begin
         slot_res = dhtt_pkg::PORT_SLOT_W'(target_ff);
      end
      if (op_ff == dhtt_pkg::OP_LOOKUP) begin
         value_res = (status_ff == dhtt_pkg::ST_FOUND) ? kv_rd_ff[dhtt_pkg::WORD_W-1:0]
                                                       : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= slot_res;
         rsp_value_ff  <= value_res;
         rsp_count_ff  <= dhtt_pkg::CFG_W'(live_ff);
         rsp_grow_ff   <= (used_ff >= CNT_W'(grow_threshold));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_needs_grow  = rsp_grow_ff;

   assign sts.op          = op_ff;
   assign sts.div_last    = (step_ff == STEP_W'(dhtt_pkg::DIV_STEPS - 1));
   assign sts.flag_empty  = flag_rd_ff[1];
   assign sts.flag_del    = flag_rd_ff[0];
   assign sts.key_match   = (kv_rd_ff[KV_W-1 -: 2*dhtt_pkg::WORD_W] == {w_ff, f_ff});
   assign sts.wrap        = (i_in == start_ff);
   assign sts.reuse_valid = reuse_valid_ff;
   assign sts.reuse_any   = reuse_valid_ff | flag_rd_ff[0];
   assign sts.idx_ok      = (32'(idx_ff) < 32'(nb_ff));
   assign sts.clr_last    = (clr_cnt_ff == SLOT_W'(MAX_BUCKETS - 1));
   assign sts.rsp_free    = !rsp_valid_ff || !rsp_stall;

endmodule
